// ----- rtl/sdtq_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the thread queue.
`timescale 1ns / 1ps
package sdtq_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int NUM_QUEUES  = 2;
  localparam int NODE_COUNT  = NUM_ENTRIES + NUM_QUEUES;

  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int ENTRY_W = $clog2(NUM_ENTRIES);
  localparam int Q_W     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int GUARD_W = $clog2(NUM_ENTRIES + 1);

  localparam int KEY_W  = 32;
  localparam int OP_W   = 3;
  localparam int QSEL_W = 1;
  localparam int ID_W   = 8;
  localparam int ST_W   = 3;

  localparam logic [OP_W-1:0] OP_SORT_INS     = 3'd0;
  localparam logic [OP_W-1:0] OP_DELTA_INS    = 3'd1;
  localparam logic [OP_W-1:0] OP_DEQUEUE      = 3'd2;
  localparam logic [OP_W-1:0] OP_DETACH       = 3'd3;
  localparam logic [OP_W-1:0] OP_DETACH_CARRY = 3'd4;

  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_ID     = 3'd1;
  localparam logic [ST_W-1:0] ST_QUEUED     = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_QUEUED = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY      = 3'd4;

  typedef struct packed {
    logic            ld_req;
    logic            rd_head;
    logic            walk_start;
    logic            walk_step;
    logic            walk_stop;
    logic            lnk1;
    logic            lnk2;
    logic            un_rd_id;
    logic            un_rd_cur;
    logic            un_s;
    logic            un_carry;
    logic            set_st;
    logic [ST_W-1:0] st_code;
    logic            out_ld;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            id_bad;
    logic            id_linked;
    logic            walk_go;
    logic            head_empty;
    logic            carry_ok;
  } sts_t;

endpackage

// ----- rtl/sdtq_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module sdtq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sdtq_ctrl.sv -----
// Controller state machine sequencing insert, dequeue and detach requests.
`timescale 1ns / 1ps
module sdtq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  sdtq_pkg::sts_t  sts_i,
  output sdtq_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_HEAD  = 4'd2;
  localparam logic [3:0] S_WALK  = 4'd3;
  localparam logic [3:0] S_LNK1  = 4'd4;
  localparam logic [3:0] S_LNK2  = 4'd5;
  localparam logic [3:0] S_DQ    = 4'd6;
  localparam logic [3:0] S_UNL   = 4'd7;
  localparam logic [3:0] S_CARRY = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_req = 1'b1;
          state_d      = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts_i.op) inside
          sdtq_pkg::OP_SORT_INS, sdtq_pkg::OP_DELTA_INS: begin
            if (sts_i.id_bad) begin
              cmd_o.set_st  = 1'b1;
              cmd_o.st_code = sdtq_pkg::ST_BAD_ID;
              state_d       = S_DONE;
            end else if (sts_i.id_linked) begin
              cmd_o.set_st  = 1'b1;
              cmd_o.st_code = sdtq_pkg::ST_QUEUED;
              state_d       = S_DONE;
            end else begin
              cmd_o.rd_head = 1'b1;
              state_d       = S_HEAD;
            end
          end
          sdtq_pkg::OP_DEQUEUE: begin
            cmd_o.rd_head = 1'b1;
            state_d       = S_DQ;
          end
          sdtq_pkg::OP_DETACH, sdtq_pkg::OP_DETACH_CARRY: begin
            if (sts_i.id_bad) begin
              cmd_o.set_st  = 1'b1;
              cmd_o.st_code = sdtq_pkg::ST_BAD_ID;
              state_d       = S_DONE;
            end else if (!sts_i.id_linked) begin
              cmd_o.set_st  = 1'b1;
              cmd_o.st_code = sdtq_pkg::ST_NOT_QUEUED;
              state_d       = S_DONE;
            end else begin
              cmd_o.un_rd_id = 1'b1;
              state_d        = S_UNL;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_HEAD: begin
        cmd_o.walk_start = 1'b1;
        state_d          = S_WALK;
      end
      S_WALK: begin
        if (sts_i.walk_go) begin
          cmd_o.walk_step = 1'b1;
        end else begin
          cmd_o.walk_stop = 1'b1;
          state_d         = S_LNK1;
        end
      end
      S_LNK1: begin
        cmd_o.lnk1 = 1'b1;
        state_d    = S_LNK2;
      end
      S_LNK2: begin
        cmd_o.lnk2 = 1'b1;
        state_d    = S_DONE;
      end
      S_DQ: begin
        if (sts_i.head_empty) begin
          cmd_o.set_st  = 1'b1;
          cmd_o.st_code = sdtq_pkg::ST_EMPTY;
          state_d       = S_DONE;
        end else begin
          cmd_o.un_rd_cur = 1'b1;
          state_d         = S_UNL;
        end
      end
      S_UNL: begin
        cmd_o.un_s = 1'b1;
        state_d    = sts_i.carry_ok ? S_CARRY : S_DONE;
      end
      S_CARRY: begin
        cmd_o.un_carry = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/sdtq_dp.sv -----
// Datapath: link and key stores, walk registers, flags and the result register.
`timescale 1ns / 1ps
module sdtq_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sdtq_pkg::cmd_t                 cmd_i,
  output sdtq_pkg::sts_t                 sts_o,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_delta_queue_i,
  input  logic [sdtq_pkg::OP_W-1:0]      opcode_i,
  input  logic [sdtq_pkg::QSEL_W-1:0]    queue_sel_i,
  input  logic [sdtq_pkg::ID_W-1:0]      thread_id_i,
  input  logic [sdtq_pkg::KEY_W-1:0]     key_value_i,
  output logic [sdtq_pkg::ST_W-1:0]      status_o,
  output logic [sdtq_pkg::ID_W-1:0]      thread_out_o
);

  localparam int NW = sdtq_pkg::NODE_W;
  localparam int EW = sdtq_pkg::ENTRY_W;
  localparam int KW = sdtq_pkg::KEY_W;
  localparam logic [NW-1:0] ENT_LIMIT = NW'(sdtq_pkg::NUM_ENTRIES);

  // request and walk registers
  logic [sdtq_pkg::OP_W-1:0]    op_q;
  logic [sdtq_pkg::Q_W-1:0]     qidx_q;
  logic [NW-1:0]                root_q;
  logic [sdtq_pkg::ID_W-1:0]    id_q;
  logic [KW-1:0]                rem_q;
  logic [KW-1:0]                keyn_q;
  logic [NW-1:0]                cur_q;
  logic [NW-1:0]                node_q;
  logic [NW-1:0]                s_q;
  logic [sdtq_pkg::GUARD_W-1:0] guard_q;
  logic [sdtq_pkg::ST_W-1:0]    st_q;
  logic [sdtq_pkg::ST_W-1:0]    status_q;
  logic [sdtq_pkg::ID_W-1:0]    tout_q;
  logic [sdtq_pkg::ID_W-1:0]    thread_out_q;

  // control state
  logic                              dq_q;
  logic [sdtq_pkg::NUM_ENTRIES-1:0]  lnk_q;
  logic [sdtq_pkg::NODE_COUNT-1:0]   nx_vld_q;
  logic [sdtq_pkg::NODE_COUNT-1:0]   pv_vld_q;
  logic                              nx_hit_q;
  logic                              pv_hit_q;
  logic [NW-1:0]                     nx_ra_q;
  logic [NW-1:0]                     pv_ra_q;

  logic [sdtq_pkg::Q_W-1:0] qsat;
  logic [NW-1:0]            id_node;
  logic [EW-1:0]            id_ent;
  logic                     is_delta;

  logic [NW-1:0] nx_ram_rd, pv_ram_rd, nx_rd, pv_rd;
  logic [KW-1:0] key_rd;

  logic [NW-1:0] nx_ra, pv_ra, nx_wa, pv_wa, nx_wd, pv_wd;
  logic [EW-1:0] kr_ra, kr_wa;
  logic [KW-1:0] kr_wd;
  logic          nx_we, pv_we, kr_we;

  assign qsat = (32'(queue_sel_i) >= sdtq_pkg::NUM_QUEUES) ?
                sdtq_pkg::Q_W'(sdtq_pkg::NUM_QUEUES - 1) : sdtq_pkg::Q_W'(queue_sel_i);
  assign id_ent   = id_q[EW-1:0];
  assign id_node  = NW'(id_ent);
  assign is_delta = (op_q == sdtq_pkg::OP_DELTA_INS);

  // link entries never written read back as pointing to themselves
  assign nx_rd = nx_hit_q ? nx_ram_rd : nx_ra_q;
  assign pv_rd = pv_hit_q ? pv_ram_rd : pv_ra_q;

  always_comb begin
    nx_ra = cur_q;
    pv_ra = cur_q;
    kr_ra = cur_q[EW-1:0];
    if (cmd_i.rd_head) begin
      nx_ra = root_q;
    end
    if (cmd_i.walk_start || cmd_i.walk_step || cmd_i.un_rd_cur) begin
      nx_ra = nx_rd;
      pv_ra = nx_rd;
      kr_ra = nx_rd[EW-1:0];
    end
    if (cmd_i.un_rd_id) begin
      nx_ra = id_node;
      pv_ra = id_node;
      kr_ra = id_ent;
    end
    if (cmd_i.un_s) begin
      kr_ra = nx_rd[EW-1:0];
    end
  end

  always_comb begin
    kr_we = 1'b0;
    kr_wa = cur_q[EW-1:0];
    kr_wd = key_rd - rem_q;
    if (cmd_i.walk_stop && is_delta && (cur_q != root_q)) begin
      kr_we = 1'b1;
    end
    if (cmd_i.lnk1) begin
      kr_we = 1'b1;
      kr_wa = id_ent;
      kr_wd = rem_q;
    end
    if (cmd_i.un_carry) begin
      kr_we = 1'b1;
      kr_wa = s_q[EW-1:0];
      kr_wd = key_rd + keyn_q;
    end
  end

  always_comb begin
    nx_we = cmd_i.lnk1 | cmd_i.lnk2 | cmd_i.un_s;
    pv_we = nx_we;
    nx_wa = pv_rd;
    nx_wd = id_node;
    pv_wa = id_node;
    pv_wd = pv_rd;
    if (cmd_i.lnk2) begin
      nx_wa = id_node;
      nx_wd = cur_q;
      pv_wa = cur_q;
      pv_wd = id_node;
    end
    if (cmd_i.un_s) begin
      nx_wa = pv_rd;
      nx_wd = nx_rd;
      pv_wa = nx_rd;
      pv_wd = pv_rd;
    end
  end

  sdtq_ram #(.WIDTH(NW), .DEPTH(sdtq_pkg::NODE_COUNT)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (nx_wa),
    .wdata_i (nx_wd),
    .raddr_i (nx_ra),
    .rdata_o (nx_ram_rd)
  );

  sdtq_ram #(.WIDTH(NW), .DEPTH(sdtq_pkg::NODE_COUNT)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (pv_we),
    .waddr_i (pv_wa),
    .wdata_i (pv_wd),
    .raddr_i (pv_ra),
    .rdata_o (pv_ram_rd)
  );

  sdtq_ram #(.WIDTH(KW), .DEPTH(sdtq_pkg::NUM_ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (kr_we),
    .waddr_i (kr_wa),
    .wdata_i (kr_wd),
    .raddr_i (kr_ra),
    .rdata_o (key_rd)
  );

  always_comb begin
    sts_o            = '0;
    sts_o.op         = op_q;
    sts_o.id_bad     = (32'(id_q) >= sdtq_pkg::NUM_ENTRIES);
    sts_o.id_linked  = lnk_q[id_ent];
    sts_o.walk_go    = (cur_q != root_q) &&
                       (guard_q < sdtq_pkg::GUARD_W'(sdtq_pkg::NUM_ENTRIES)) &&
                       (key_rd <= rem_q);
    sts_o.head_empty = (nx_rd == root_q) || (nx_rd >= ENT_LIMIT);
    sts_o.carry_ok   = (nx_rd < ENT_LIMIT) &&
                       (((op_q == sdtq_pkg::OP_DEQUEUE) && (32'(qidx_q) == 32'(dq_q))) ||
                        (op_q == sdtq_pkg::OP_DETACH_CARRY));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dq_q     <= 1'b1;
      lnk_q    <= '0;
      nx_vld_q <= '0;
      pv_vld_q <= '0;
      nx_hit_q <= 1'b0;
      pv_hit_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        dq_q <= cfg_delta_queue_i;
      end
      if (nx_we) begin
        nx_vld_q[nx_wa] <= 1'b1;
      end
      if (pv_we) begin
        pv_vld_q[pv_wa] <= 1'b1;
      end
      nx_hit_q <= nx_vld_q[nx_ra];
      pv_hit_q <= pv_vld_q[pv_ra];
      if (cmd_i.lnk2) begin
        lnk_q[id_ent] <= 1'b1;
      end
      if (cmd_i.un_s) begin
        lnk_q[node_q[EW-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    nx_ra_q <= nx_ra;
    pv_ra_q <= pv_ra;
    if (cmd_i.ld_req) begin
      op_q   <= opcode_i;
      qidx_q <= qsat;
      root_q <= ENT_LIMIT + NW'(qsat);
      id_q   <= thread_id_i;
      rem_q  <= key_value_i;
      st_q   <= sdtq_pkg::ST_OK;
      tout_q <= '0;
    end
    if (cmd_i.set_st) begin
      st_q <= cmd_i.st_code;
    end
    if (cmd_i.walk_start) begin
      cur_q   <= nx_rd;
      guard_q <= '0;
    end
    if (cmd_i.walk_step) begin
      cur_q   <= nx_rd;
      guard_q <= guard_q + 1'b1;
      if (is_delta) begin
        rem_q <= rem_q - key_rd;
      end
    end
    if (cmd_i.un_rd_id) begin
      node_q <= id_node;
    end
    if (cmd_i.un_rd_cur) begin
      node_q <= nx_rd;
      tout_q <= sdtq_pkg::ID_W'(nx_rd);
    end
    if (cmd_i.un_s) begin
      s_q    <= nx_rd;
      keyn_q <= key_rd;
    end
    if (cmd_i.out_ld) begin
      status_q     <= st_q;
      thread_out_q <= tout_q;
    end
  end

  assign status_o     = status_q;
  assign thread_out_o = thread_out_q;

endmodule

// ----- rtl/sorted_and_delta_thread_queue.sv -----
// Thread queue top level: sorted and delta ordered linked queues over one entry table.
// A bad, queued or unqueued id or an unused opcode is answered straight from decode; an
// insert walks the queue one link per cycle and passes at most NUM_ENTRIES entries.
// One request at a time; the next is accepted only after the result is registered.
// Reset returns all queues empty, all entries unqueued and the delta queue to queue 1.
`timescale 1ns / 1ps
module sorted_and_delta_thread_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [sdtq_pkg::OP_W-1:0]    opcode_i,
  input  logic [sdtq_pkg::QSEL_W-1:0]  queue_sel_i,
  input  logic [sdtq_pkg::ID_W-1:0]    thread_id_i,
  input  logic [sdtq_pkg::KEY_W-1:0]   key_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sdtq_pkg::ST_W-1:0]    status_o,
  output logic [sdtq_pkg::ID_W-1:0]    thread_out_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_delta_queue_i
);

  sdtq_pkg::cmd_t cmd;
  sdtq_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  sdtq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sdtq_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_delta_queue_i (cfg_delta_queue_i),
    .opcode_i          (opcode_i),
    .queue_sel_i       (queue_sel_i),
    .thread_id_i       (thread_id_i),
    .key_value_i       (key_value_i),
    .status_o          (status_o),
    .thread_out_o      (thread_out_o)
  );

endmodule
